[rtl/core/larenv_pkg.sv]
package larenv_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W  = 16;
    localparam int COUNT_W   = 20;
    localparam int FRAC_W    = 16;
    localparam int AMP_W     = FRAC_W + 1;
    localparam int MUL_W     = ((SAMPLE_W > COUNT_W) ? SAMPLE_W : COUNT_W) + 2;
    localparam int PROD_W    = MUL_W + AMP_W;
    localparam int STEP_W    = $clog2(AMP_W + 1);
    localparam int CFG_IDX_W = 2;

    // Unity gain in Q1.16.
    localparam logic [AMP_W-1:0] FULL_SCALE = {1'b1, {FRAC_W{1'b0}}};

    // Item kinds on the input channel.
    localparam logic [1:0] MODE_SAMPLE   = 2'd0;
    localparam logic [1:0] MODE_NOTE_ON  = 2'd1;
    localparam logic [1:0] MODE_NOTE_OFF = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd1;

    // Envelope stage.
    typedef enum logic [1:0] {
        STAGE_IDLE    = 2'd0,
        STAGE_ATTACK  = 2'd1,
        STAGE_SUSTAIN = 2'd2,
        STAGE_RELEASE = 2'd3
    } stage_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_DIV  = 2'd1,
        FSM_MUL  = 2'd2,
        FSM_OUT  = 2'd3
    } fsm_t;

endpackage

[rtl/core/linear_attack_release_envelope.sv]
// Linear attack/release envelope on a stream of audio samples.
// Input channel (s_valid/s_ready): one beat is a sample, a note-on or a note-off,
// chosen by s_mode. Only sample beats produce a beat on the result channel
// (m_valid/m_ready), carrying the scaled sample, the gain used and the stage.
// Ramp lengths in frames are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while idle; the block itself does not enforce it.
// Each beat is worked on alone with one bit per cycle: a restoring divider gives
// the ramp gain, and a shift-add multiplier applies it. A sample on a ramp goes
// through the divider and then the multiplier; a sample in idle, sustain or at a
// ramp end goes through the multiplier only. A note event that changes the stage
// keeps s_ready low while the restart point is computed; an ignored note event
// leaves s_ready high. The result sits in an output register, so the next beat
// is accepted while a result waits; a stalled receiver only holds the block once
// a second result is finished. Reset (aresetn low, synchronous) clears the stage
// to idle, the gain and counter to zero, both ramp lengths to zero, and drops
// m_valid.
module linear_attack_release_envelope (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [1:0]                               s_mode,
    input  logic signed [larenv_pkg::SAMPLE_W-1:0]   s_sample_in,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [larenv_pkg::SAMPLE_W-1:0]   m_sample_out,
    output logic [larenv_pkg::AMP_W-1:0]             m_gain,
    output logic [1:0]                               m_phase,
    input  logic                                     cfg_we,
    input  logic [larenv_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [larenv_pkg::COUNT_W-1:0]           cfg_data
);

    localparam int SW = larenv_pkg::SAMPLE_W;
    localparam int CW = larenv_pkg::COUNT_W;
    localparam int FW = larenv_pkg::FRAC_W;
    localparam int AW = larenv_pkg::AMP_W;
    localparam int MW = larenv_pkg::MUL_W;
    localparam int PW = larenv_pkg::PROD_W;
    localparam int TW = larenv_pkg::STEP_W;

    // State and datapath registers.
    larenv_pkg::fsm_t          fsm_reg, fsm_next;
    larenv_pkg::stage_t        stage_reg, stage_next;
    logic [CW-1:0]             attack_frames_reg, attack_frames_next;
    logic [CW-1:0]             release_frames_reg, release_frames_next;
    logic [CW-1:0]             ramp_cnt_reg, ramp_cnt_next;
    logic [AW-1:0]             amp_reg, amp_next;
    logic [TW-1:0]             step_reg, step_next;
    logic [CW-1:0]             rem_reg, rem_next;
    logic [FW-1:0]             quo_reg, quo_next;
    logic                      rel_div_reg, rel_div_next;
    logic                      is_note_reg, is_note_next;
    logic signed [MW-1:0]      mcand_reg, mcand_next;
    logic signed [MW-1:0]      hi_reg, hi_next;
    logic [AW-1:0]             lo_reg, lo_next;
    logic                      m_valid_reg, m_valid_next;
    logic signed [SW-1:0]      m_sample_out_reg, m_sample_out_next;
    logic [AW-1:0]             m_gain_reg, m_gain_next;
    logic [1:0]                m_phase_reg, m_phase_next;

    // Decode and step signals.
    logic                      accept;
    logic [CW-1:0]             ramp_frames;
    logic                      ramp_end;
    logic                      start_div;
    logic                      note_on_go;
    logic                      note_off_go;
    logic                      start_mul;
    logic                      div_done;
    logic                      mul_done;
    logic                      out_free;
    logic                      out_load;
    logic [CW:0]               rem_sh;
    logic [CW:0]               rem_diff;
    logic                      rem_ge;
    logic [FW-1:0]             quo_final;
    logic [AW-1:0]             ramp_amp;
    logic signed [MW-1:0]      mul_sum;
    logic [PW-1:0]             prod_next;
    logic [PW-1:0]             prod_reg;

    // Decide what an accepted beat starts.
    always_comb begin
        accept      = s_valid && s_ready;
        ramp_frames = (stage_reg == larenv_pkg::STAGE_RELEASE) ? release_frames_reg
                                                                : attack_frames_reg;
        ramp_end    = (ramp_frames == '0) || (ramp_cnt_reg >= ramp_frames);
        start_div   = accept && (s_mode == larenv_pkg::MODE_SAMPLE) && !ramp_end &&
                      ((stage_reg == larenv_pkg::STAGE_ATTACK) ||
                       (stage_reg == larenv_pkg::STAGE_RELEASE));
        note_on_go  = accept && (s_mode == larenv_pkg::MODE_NOTE_ON) &&
                      (stage_reg != larenv_pkg::STAGE_ATTACK);
        note_off_go = accept && (s_mode == larenv_pkg::MODE_NOTE_OFF) &&
                      ((stage_reg == larenv_pkg::STAGE_ATTACK) ||
                       (stage_reg == larenv_pkg::STAGE_SUSTAIN));
        start_mul   = (accept && (s_mode == larenv_pkg::MODE_SAMPLE) && !start_div) ||
                      note_on_go || note_off_go;
        div_done    = (fsm_reg == larenv_pkg::FSM_DIV) && (step_reg == TW'(1));
        mul_done    = (fsm_reg == larenv_pkg::FSM_MUL) && (step_reg == TW'(1));
        out_free    = !m_valid_reg || m_ready;
    end

    // Next state of the sequencer.
    always_comb begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            larenv_pkg::FSM_IDLE: begin
                if (start_div) begin
                    fsm_next = larenv_pkg::FSM_DIV;
                end else if (start_mul) begin
                    fsm_next = larenv_pkg::FSM_MUL;
                end
            end
            larenv_pkg::FSM_DIV: begin
                if (div_done) begin
                    fsm_next = larenv_pkg::FSM_MUL;
                end
            end
            larenv_pkg::FSM_MUL: begin
                if (mul_done) begin
                    fsm_next = is_note_reg ? larenv_pkg::FSM_IDLE : larenv_pkg::FSM_OUT;
                end
            end
            larenv_pkg::FSM_OUT: begin
                if (out_free) begin
                    fsm_next = larenv_pkg::FSM_IDLE;
                end
            end
            default: begin
                fsm_next = larenv_pkg::FSM_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_ready  = (fsm_reg == larenv_pkg::FSM_IDLE);
        out_load = (fsm_reg == larenv_pkg::FSM_OUT) && out_free;
    end

    // One divider bit: shift the remainder and try the subtraction.
    always_comb begin
        rem_sh    = {rem_reg, 1'b0};
        rem_diff  = rem_sh - {1'b0, rel_div_reg ? release_frames_reg : attack_frames_reg};
        rem_ge    = !rem_diff[CW];
        quo_final = {quo_reg[FW-2:0], rem_ge};
        ramp_amp  = rel_div_reg ? (larenv_pkg::FULL_SCALE - {1'b0, quo_final})
                                : {1'b0, quo_final};
    end

    // One multiplier bit: add the multiplicand and shift right arithmetically.
    always_comb begin
        mul_sum   = hi_reg + (lo_reg[0] ? mcand_reg : '0);
        prod_next = {mul_sum[MW-1], mul_sum, lo_reg[AW-1:1]};
        prod_reg  = {hi_reg, lo_reg};
    end

    // Datapath next values.
    always_comb begin
        stage_next          = stage_reg;
        attack_frames_next  = attack_frames_reg;
        release_frames_next = release_frames_reg;
        ramp_cnt_next       = ramp_cnt_reg;
        amp_next            = amp_reg;
        step_next           = step_reg;
        rem_next            = rem_reg;
        quo_next            = quo_reg;
        rel_div_next        = rel_div_reg;
        is_note_next        = is_note_reg;
        mcand_next          = mcand_reg;
        hi_next             = hi_reg;
        lo_next             = lo_reg;
        m_valid_next        = m_valid_reg;
        m_sample_out_next   = m_sample_out_reg;
        m_gain_next         = m_gain_reg;
        m_phase_next        = m_phase_reg;

        // Configuration writes.
        if (cfg_we) begin
            case (cfg_index)
                larenv_pkg::REG_ATTACK:  attack_frames_next  = cfg_data;
                larenv_pkg::REG_RELEASE: release_frames_next = cfg_data;
                default: ;
            endcase
        end

        // Accepted beat: update the stage and load the divider or multiplier.
        if (accept) begin
            hi_next = '0;
            case (s_mode)
                larenv_pkg::MODE_SAMPLE: begin
                    is_note_next = 1'b0;
                    mcand_next   = MW'(s_sample_in);
                    if (start_div) begin
                        rem_next      = ramp_cnt_reg;
                        rel_div_next  = (stage_reg == larenv_pkg::STAGE_RELEASE);
                        ramp_cnt_next = ramp_cnt_reg + 1'b1;
                        step_next     = TW'(FW);
                    end else begin
                        step_next = TW'(AW);
                        case (stage_reg)
                            larenv_pkg::STAGE_ATTACK: begin
                                amp_next   = larenv_pkg::FULL_SCALE;
                                stage_next = larenv_pkg::STAGE_SUSTAIN;
                            end
                            larenv_pkg::STAGE_SUSTAIN: begin
                                amp_next = larenv_pkg::FULL_SCALE;
                            end
                            larenv_pkg::STAGE_RELEASE: begin
                                amp_next   = '0;
                                stage_next = larenv_pkg::STAGE_IDLE;
                            end
                            default: begin
                                amp_next = '0;
                            end
                        endcase
                        lo_next = amp_next;
                    end
                end
                larenv_pkg::MODE_NOTE_ON: begin
                    if (note_on_go) begin
                        stage_next   = larenv_pkg::STAGE_ATTACK;
                        is_note_next = 1'b1;
                        mcand_next   = MW'(attack_frames_reg);
                        lo_next      = amp_reg;
                        step_next    = TW'(AW);
                    end
                end
                larenv_pkg::MODE_NOTE_OFF: begin
                    if (note_off_go) begin
                        stage_next   = larenv_pkg::STAGE_RELEASE;
                        is_note_next = 1'b1;
                        mcand_next   = MW'(release_frames_reg);
                        lo_next      = larenv_pkg::FULL_SCALE - amp_reg;
                        step_next    = TW'(AW);
                    end
                end
                default: ;
            endcase
        end

        // Divider iteration; the last bit hands the gain to the multiplier.
        if (fsm_reg == larenv_pkg::FSM_DIV) begin
            rem_next  = rem_ge ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
            quo_next  = quo_final;
            step_next = step_reg - 1'b1;
            if (div_done) begin
                amp_next  = ramp_amp;
                lo_next   = ramp_amp;
                hi_next   = '0;
                step_next = TW'(AW);
            end
        end

        // Multiplier iteration; a note event takes its restart point here.
        if (fsm_reg == larenv_pkg::FSM_MUL) begin
            hi_next   = prod_next[PW-1:AW];
            lo_next   = prod_next[AW-1:0];
            step_next = step_reg - 1'b1;
            if (mul_done && is_note_reg) begin
                ramp_cnt_next = prod_next[FW +: CW];
            end
        end

        // Output register.
        if (out_load) begin
            m_valid_next      = 1'b1;
            m_sample_out_next = prod_reg[FW +: SW];
            m_gain_next       = amp_reg;
            m_phase_next      = stage_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control and envelope state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg            <= larenv_pkg::FSM_IDLE;
            stage_reg          <= larenv_pkg::STAGE_IDLE;
            attack_frames_reg  <= '0;
            release_frames_reg <= '0;
            ramp_cnt_reg       <= '0;
            amp_reg            <= '0;
            step_reg           <= '0;
            rel_div_reg        <= 1'b0;
            is_note_reg        <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            fsm_reg            <= fsm_next;
            stage_reg          <= stage_next;
            attack_frames_reg  <= attack_frames_next;
            release_frames_reg <= release_frames_next;
            ramp_cnt_reg       <= ramp_cnt_next;
            amp_reg            <= amp_next;
            step_reg           <= step_next;
            rel_div_reg        <= rel_div_next;
            is_note_reg        <= is_note_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    // Shift registers and result payload.
    always_ff @(posedge aclk) begin
        rem_reg          <= rem_next;
        quo_reg          <= quo_next;
        mcand_reg        <= mcand_next;
        hi_reg           <= hi_next;
        lo_reg           <= lo_next;
        m_sample_out_reg <= m_sample_out_next;
        m_gain_reg       <= m_gain_next;
        m_phase_reg      <= m_phase_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;
    assign m_gain       = m_gain_reg;
    assign m_phase      = m_phase_reg;

`ifndef SYNTHESIS
    // The gain never exceeds unity.
    a_amp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        amp_reg <= larenv_pkg::FULL_SCALE)
        else $error("amplitude above full scale");

    // A result in sustain carries unity gain.
    a_sustain_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_phase_reg == larenv_pkg::STAGE_SUSTAIN)) |->
        (m_gain_reg == larenv_pkg::FULL_SCALE))
        else $error("sustain result without unity gain");

    // A result in idle is silent.
    a_idle_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_phase_reg == larenv_pkg::STAGE_IDLE)) |->
        ((m_gain_reg == '0) && (m_sample_out_reg == '0)))
        else $error("idle result not silent");

    // An accepted sample always starts work.
    a_sample_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_mode == larenv_pkg::MODE_SAMPLE)) |=>
        (fsm_reg != larenv_pkg::FSM_IDLE))
        else $error("sample beat dropped");
`endif

endmodule

[bench/envelope_checker.sv]
`timescale 1ns / 1ps

module envelope_checker (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    input  logic                                     s_ready,
    input  logic [1:0]                               s_mode,
    input  logic signed [larenv_pkg::SAMPLE_W-1:0]   s_sample_in,
    input  logic                                     m_valid,
    input  logic                                     m_ready,
    input  logic signed [larenv_pkg::SAMPLE_W-1:0]   m_sample_out,
    input  logic [larenv_pkg::AMP_W-1:0]             m_gain,
    input  logic [1:0]                               m_phase,
    input  logic                                     cfg_we,
    input  logic [larenv_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [larenv_pkg::COUNT_W-1:0]           cfg_data,
    output int                                       mismatches,
    output int                                       outstanding
);
    import larenv_pkg::*;

    // One scaled sample as the result channel carries it.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic [AMP_W-1:0]           gain;
        stage_t                     phase;
    } scaled_beat_t;

    // Shadow of the envelope state and of the two ramp lengths.
    stage_t               stage;
    logic [COUNT_W-1:0]   ramp;
    logic [AMP_W-1:0]     amp;
    logic [COUNT_W-1:0]   attack_len;
    logic [COUNT_W-1:0]   release_len;

    // Scaled samples predicted but not yet seen on the result channel.
    scaled_beat_t scaled_due[$];

    bit           produced;
    scaled_beat_t beat;
    scaled_beat_t want;

    // Advance the envelope by one input beat and work out the scaled sample, if any.
    task automatic apply_envelope(input logic [1:0] mode,
                                  input logic signed [SAMPLE_W-1:0] smp,
                                  output bit made, output scaled_beat_t res);
        longint unsigned num;
        longint          product;
        made = 1'b0;
        res  = '0;
        case (mode)
            MODE_NOTE_ON: begin
                // Restart the attack at the point matching the present level.
                if (stage != STAGE_ATTACK) begin
                    stage = STAGE_ATTACK;
                    ramp  = '0;
                    if (amp != '0 && attack_len != '0) begin
                        num  = 64'(amp) * 64'(attack_len);
                        ramp = COUNT_W'(num >> FRAC_W);
                    end
                end
            end
            MODE_NOTE_OFF: begin
                // Release only from attack or sustain, again without a jump in level.
                if (stage != STAGE_RELEASE && stage != STAGE_IDLE) begin
                    stage = STAGE_RELEASE;
                    ramp  = '0;
                    if (amp < FULL_SCALE && release_len != '0) begin
                        num  = 64'(FULL_SCALE - amp) * 64'(release_len);
                        ramp = COUNT_W'(num >> FRAC_W);
                    end
                end
            end
            MODE_SAMPLE: begin
                case (stage)
                    STAGE_ATTACK: begin
                        if (attack_len == '0 || ramp >= attack_len) begin
                            amp   = FULL_SCALE;
                            stage = STAGE_SUSTAIN;
                        end else begin
                            num  = (64'(ramp) << FRAC_W) / 64'(attack_len);
                            amp  = AMP_W'(num);
                            ramp = ramp + 1'b1;
                        end
                    end
                    STAGE_SUSTAIN: amp = FULL_SCALE;
                    STAGE_RELEASE: begin
                        if (release_len == '0 || ramp >= release_len) begin
                            amp   = '0;
                            stage = STAGE_IDLE;
                        end else begin
                            num  = (64'(ramp) << FRAC_W) / 64'(release_len);
                            amp  = FULL_SCALE - AMP_W'(num);
                            ramp = ramp + 1'b1;
                        end
                    end
                    default: amp = '0;
                endcase
                // The arithmetic shift of a signed product rounds toward minus infinity.
                product        = longint'(smp) * longint'({1'b0, amp});
                res.sample_out = SAMPLE_W'(product >>> FRAC_W);
                res.gain       = amp;
                res.phase      = stage;
                made           = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Track register writes and both handshakes at every rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            stage       = STAGE_IDLE;
            ramp        = '0;
            amp         = '0;
            attack_len  = '0;
            release_len = '0;
            mismatches  = 0;
            scaled_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ATTACK:  attack_len  = cfg_data;
                    REG_RELEASE: release_len = cfg_data;
                    default: ;
                endcase
            end

            // A result beat always belongs to an older sample, so compare first.
            if (m_valid && m_ready) begin
                if (scaled_due.size() == 0) begin
                    $display("%0t: result with nothing expected: sample_out %0d gain %0d phase %0d",
                             $time, m_sample_out, m_gain, m_phase);
                    mismatches++;
                end else begin
                    want = scaled_due.pop_front();
                    if (m_sample_out !== want.sample_out) begin
                        $display("%0t: sample_out expected %0d, got %0d",
                                 $time, want.sample_out, m_sample_out);
                        mismatches++;
                    end
                    if (m_gain !== want.gain) begin
                        $display("%0t: gain expected %0d, got %0d", $time, want.gain, m_gain);
                        mismatches++;
                    end
                    if (m_phase !== want.phase) begin
                        $display("%0t: phase expected %0d, got %0d", $time, want.phase, m_phase);
                        mismatches++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                apply_envelope(s_mode, s_sample_in, produced, beat);
                if (produced) begin
                    scaled_due.push_back(beat);
                end
            end
        end
        outstanding = scaled_due.size();
    end

endmodule

[bench/linear_attack_release_envelope_test.sv]
`timescale 1ns / 1ps

module linear_attack_release_envelope_test;
    import larenv_pkg::*;

    // Input kind that the block must ignore, and register indexes it does not decode.
    localparam logic [1:0]           MODE_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam logic [COUNT_W-1:0]   LEN_MAX      = '1;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 2000;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_mode = MODE_SAMPLE;
    logic signed [SAMPLE_W-1:0] s_sample_in = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample_out;
    logic [AMP_W-1:0]           m_gain;
    logic [1:0]                 m_phase;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = REG_ATTACK;
    logic [COUNT_W-1:0]         cfg_data = '0;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    int m_hold = 0;
    bit s_calm = 1'b0;
    bit m_calm = 1'b0;

    always #1 aclk = ~aclk;

    linear_attack_release_envelope DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_gain       (m_gain),
        .m_phase      (m_phase),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    envelope_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_gain       (m_gain),
        .m_phase      (m_phase),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // Gap length: mostly none or a few cycles, now and then a long one.
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    // Random audio with the full-scale values mixed in.
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 19))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offer one beat after an optional gap and hold it until it is taken.
    task automatic send_beat(input logic [1:0] mode, input logic signed [SAMPLE_W-1:0] smp);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            s_calm = ~s_calm;
        end
        gap = pick_gap(s_calm);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_mode      = mode;
        s_sample_in = smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Wait for every scaled sample, then give a trailing note event time to finish.
    task automatic settle();
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Mostly complete notes with random length and content, the rest loose beats.
    task automatic run_phase(input int count, input logic [COUNT_W-1:0] atk,
                             input logic [COUNT_W-1:0] rel);
        int sent;
        int k;
        int span_on;
        int span_off;
        logic [1:0] mode;
        sent     = 0;
        span_on  = (atk > 64) ? 68 : int'(atk) + 4;
        span_off = (rel > 64) ? 68 : int'(rel) + 4;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 80) begin
                send_beat(MODE_NOTE_ON, rand_sample());
                k = $urandom_range(0, span_on);
                sent += k + 2;
                repeat (k) send_beat(MODE_SAMPLE, rand_sample());
                send_beat(MODE_NOTE_OFF, rand_sample());
                k = $urandom_range(0, span_off);
                sent += k;
                repeat (k) send_beat(MODE_SAMPLE, rand_sample());
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: mode = MODE_SAMPLE;
                    5, 6:          mode = MODE_NOTE_ON;
                    7, 8:          mode = MODE_NOTE_OFF;
                    default:       mode = MODE_UNUSED;
                endcase
                send_beat(mode, rand_sample());
                if (mode != MODE_UNUSED) begin
                    sent++;
                end
            end
        end
    endtask

    // Result side: ready drops for random stretches, with calm periods in between.
    always @(negedge aclk) begin
        if ($urandom_range(0, 63) == 0) begin
            m_calm = ~m_calm;
        end
        if (m_hold > 0) begin
            m_ready = 1'b0;
            m_hold--;
        end else begin
            m_ready = 1'b1;
            m_hold  = pick_gap(m_calm);
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("linear_attack_release_envelope_test: FAIL");
            $finish;
        end
    end

    initial begin
        logic [COUNT_W-1:0] atk;
        logic [COUNT_W-1:0] rel;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Zero ramp lengths: idle output, ignored beats, instant attack and release.
        send_beat(MODE_SAMPLE, 16'sh8000);
        send_beat(MODE_NOTE_OFF, '0);
        send_beat(MODE_UNUSED, 16'sh7FFF);
        send_beat(MODE_NOTE_ON, '0);
        send_beat(MODE_SAMPLE, 16'sh7FFF);
        send_beat(MODE_SAMPLE, 16'sh8000);
        send_beat(MODE_NOTE_ON, '0);
        send_beat(MODE_SAMPLE, '1);
        send_beat(MODE_NOTE_OFF, '0);
        send_beat(MODE_SAMPLE, 16'sh3039);

        // Short ramps, undecoded register writes, and notes that interrupt a ramp.
        settle();
        write_reg(REG_ATTACK, 20'd3);
        write_reg(REG_RELEASE, 20'd2);
        write_reg(REG_SPARE_LO, LEN_MAX);
        write_reg(REG_SPARE_HI, '0);
        send_beat(MODE_NOTE_ON, '0);
        send_beat(MODE_SAMPLE, 16'sh7FFF);
        send_beat(MODE_SAMPLE, 16'sh8000);
        send_beat(MODE_NOTE_ON, '0);
        send_beat(MODE_NOTE_OFF, '0);
        send_beat(MODE_SAMPLE, 16'sh7FFF);
        send_beat(MODE_NOTE_OFF, '0);
        send_beat(MODE_NOTE_ON, '0);
        send_beat(MODE_SAMPLE, 16'sh8000);
        send_beat(MODE_SAMPLE, 16'sh7FFF);
        send_beat(MODE_SAMPLE, '1);
        send_beat(MODE_SAMPLE, 16'sh8000);

        // Longest ramps, then the release shortened below the running counter.
        settle();
        write_reg(REG_ATTACK, LEN_MAX);
        write_reg(REG_RELEASE, LEN_MAX);
        send_beat(MODE_NOTE_OFF, '0);
        send_beat(MODE_SAMPLE, 16'sh7FFF);
        send_beat(MODE_SAMPLE, 16'sh8000);
        settle();
        write_reg(REG_RELEASE, 20'd1);
        send_beat(MODE_SAMPLE, 16'sh7FFF);

        // Random phases, each under its own pair of ramp lengths.
        for (int p = 0; p < 14; p++) begin
            case (p)
                0: begin
                    atk = 20'd1;
                    rel = 20'd1;
                end
                1: begin
                    atk = LEN_MAX;
                    rel = LEN_MAX;
                end
                2: begin
                    atk = '0;
                    rel = COUNT_W'($urandom_range(1, 16));
                end
                3: begin
                    atk = COUNT_W'($urandom_range(1, 16));
                    rel = '0;
                end
                default: begin
                    atk = ($urandom_range(0, 3) == 0) ? '0 : COUNT_W'($urandom_range(1, 200));
                    rel = ($urandom_range(0, 3) == 0) ? '0 : COUNT_W'($urandom_range(1, 200));
                end
            endcase
            settle();
            write_reg(REG_ATTACK, atk);
            write_reg(REG_RELEASE, rel);
            if ($urandom_range(0, 3) == 0) begin
                write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI,
                          COUNT_W'($urandom));
            end
            run_phase((p == 1) ? 60 : 125, atk, rel);
        end

        settle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("linear_attack_release_envelope_test: PASS");
        end else begin
            $display("linear_attack_release_envelope_test: FAIL");
        end
        $finish;
    end

endmodule
